>>> hdl/tve_pkg.sv
package tve_pkg;

  localparam int PixelBits  = 16;
  localparam int SqBits     = 2 * PixelBits;
  localparam int RadBits    = SqBits + 1;
  localparam int RootBits   = PixelBits + 1;
  localparam int LambdaBits = 16;
  localparam int ProdBits   = SqBits + LambdaBits;
  localparam int SumBits    = 64;
  localparam int EnergyBits = 63;
  localparam int WidthBits  = 13;
  localparam int HeightBits = 16;
  localparam int CfgIdxBits = 2;
  localparam int CfgBits    = 16;
  localparam int DataShift  = 17;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgLambda = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkData,
    BkWaitV,
    BkWaitH,
    BkTail
  } bk_state_e;

  typedef struct packed {
    logic                  v_vld;
    logic [RadBits-1:0]    v_rad;
    logic                  h_vld;
    logic [SqBits-1:0]     h_sq;
    logic [SqBits-1:0]     d_sq;
    logic [LambdaBits-1:0] lambda;
    logic                  last;
  } job_t;

  function automatic logic [SqBits-1:0] sq_diff(input logic [PixelBits-1:0] a,
                                                input logic [PixelBits-1:0] b);
    logic [PixelBits:0] d;
    logic [PixelBits:0] m;
    d = {a[PixelBits-1], a} - {b[PixelBits-1], b};
    m = d[PixelBits] ? (~d + 1'b1) : d;
    return SqBits'(m[PixelBits-1:0]) * SqBits'(m[PixelBits-1:0]);
  endfunction

endpackage

>>> hdl/tv_energy_2d.sv
// Each pixel beat in the back end runs no root, one root or two; the bit-serial square
// root (17 steps per root) sets how long a beat takes.
// The front end takes no pixel until its last one is in the two-entry job queue.
// The frame energy is registered as the back end emits it at the last pixel's tail.
// Reset clears counters, sums and the result valid flag and sets width, height and
// lambda to 256; the line buffer RAMs are not cleared, and no unwritten entry is used.
module tv_energy_2d #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [tve_pkg::PixelBits-1:0] u_i,
  input  logic signed [tve_pkg::PixelBits-1:0] u0_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [tve_pkg::EnergyBits-1:0]       energy_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tve_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [tve_pkg::CfgBits-1:0]          cfg_data_i
);

  logic [tve_pkg::WidthBits-1:0]  width_q;
  logic [tve_pkg::HeightBits-1:0] height_q;
  logic [tve_pkg::LambdaBits-1:0] lambda_q;
  logic                           clear;

  logic                           job_valid;
  tve_pkg::job_t                  job_in;
  tve_pkg::job_t                  job_out;
  logic                           q_full;
  logic                           q_empty;
  logic                           q_pop;

  assign cfg_ready_o = 1'b1;
  assign clear = cfg_valid_i && (cfg_index_i == tve_pkg::CfgWidth ||
                                 cfg_index_i == tve_pkg::CfgHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tve_pkg::WidthBits'(256);
      height_q <= tve_pkg::HeightBits'(256);
      lambda_q <= tve_pkg::LambdaBits'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tve_pkg::CfgWidth:  width_q  <= cfg_data_i[tve_pkg::WidthBits-1:0];
        tve_pkg::CfgHeight: height_q <= cfg_data_i;
        tve_pkg::CfgLambda: lambda_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tve_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .u_i         (u_i),
    .u0_i        (u0_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .lambda_i    (lambda_q),
    .clear_i     (clear),
    .job_valid_o (job_valid),
    .job_o       (job_in),
    .job_ready_i (~q_full)
  );

  tve_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid & ~q_full),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  tve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .job_empty_i (q_empty),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .energy_o    (energy_o)
  );

endmodule

>>> hdl/tve_ram.sv
module tve_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tve_fifo.sv
module tve_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tve_pkg::job_t     data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tve_pkg::job_t     data_o
);

  tve_pkg::job_t mem_q [2];
  logic          wptr_q;
  logic          rptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Job queue written while full.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Job queue read while empty.");
`endif

endmodule

>>> hdl/tve_sqrt.sv
module tve_sqrt #(
  parameter int RootBits = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2*RootBits-1:0]   rad_i,
  output logic                    done_o,
  output logic [RootBits-1:0]     root_o
);

  localparam int RemBits = RootBits + 2;
  localparam int CntBits = $clog2(RootBits);

  logic                  busy_q;
  logic                  done_q;
  logic [CntBits-1:0]    cnt_q;
  logic [2*RootBits-1:0] rad_q;
  logic [RemBits-1:0]    rem_q;
  logic [RootBits-1:0]   root_q;
  logic [RemBits+1:0]    rem_sh;
  logic [RemBits+1:0]    trial;
  logic                  take;

  always_comb begin
    rem_sh = {rem_q, rad_q[2*RootBits-1 -: 2]};
    trial  = (RemBits+2)'({root_q, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(RootBits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[2*RootBits-3:0], 2'b00};
      if (take) begin
        rem_q  <= RemBits'(rem_sh - trial);
        root_q <= {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_q  <= RemBits'(rem_sh);
        root_q <= {root_q[RootBits-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> hdl/tve_front.sv
module tve_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic signed [tve_pkg::PixelBits-1:0] u_i,
  input  logic signed [tve_pkg::PixelBits-1:0] u0_i,
  input  logic [tve_pkg::WidthBits-1:0]      width_i,
  input  logic [tve_pkg::HeightBits-1:0]     height_i,
  input  logic [tve_pkg::LambdaBits-1:0]     lambda_i,
  input  logic                               clear_i,
  output logic                               job_valid_o,
  output tve_pkg::job_t                      job_o,
  input  logic                               job_ready_i
);

  localparam int AddrBits = $clog2(MAX_WIDTH);
  localparam int EwBits   = (AddrBits + 1 > tve_pkg::WidthBits) ? AddrBits + 1
                                                                : tve_pkg::WidthBits;

  logic [EwBits-1:0]               eff_w;
  logic [tve_pkg::HeightBits-1:0]  eff_h;
  logic                            accept;
  logic                            last_col;
  logic                            last_row;

  logic [AddrBits-1:0]             col_q;
  logic [tve_pkg::HeightBits-1:0]  row_q;
  logic [tve_pkg::PixelBits-1:0]   prev_q;

  logic                            s1_q;
  logic [tve_pkg::PixelBits-1:0]   s1_u_q;
  logic [tve_pkg::PixelBits-1:0]   s1_u0_q;
  logic [tve_pkg::PixelBits-1:0]   s1_prev_q;
  logic [AddrBits-1:0]             s1_col_q;
  logic                            s1_cpos_q;
  logic                            s1_rpos_q;
  logic                            s1_lcol_q;
  logic                            s1_lrow_q;
  logic [tve_pkg::LambdaBits-1:0]  s1_lambda_q;

  logic                            s2_q;
  tve_pkg::job_t                   job_q;
  tve_pkg::job_t                   job_d;

  logic [tve_pkg::PixelBits-1:0]   pix_rd;
  logic [tve_pkg::SqBits-1:0]      hsq_rd;
  logic [tve_pkg::SqBits-1:0]      above_h;
  logic [tve_pkg::SqBits-1:0]      v_sq;
  logic [tve_pkg::SqBits-1:0]      h_sq;

  always_comb begin
    eff_w = EwBits'(width_i);
    if (eff_w == '0) begin
      eff_w = EwBits'(1);
    end else if (eff_w > EwBits'(MAX_WIDTH)) begin
      eff_w = EwBits'(MAX_WIDTH);
    end
    eff_h    = (height_i == '0) ? tve_pkg::HeightBits'(1) : height_i;
    last_col = (EwBits'(col_q) == eff_w - 1'b1);
    last_row = (row_q == eff_h - 1'b1);
  end

  assign full   = s1_q | s2_q;
  assign accept = push & ~full;

  tve_ram #(.Width(tve_pkg::PixelBits), .Depth(MAX_WIDTH)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (u_i),
    .raddr_i (col_q),
    .rdata_o (pix_rd)
  );

  tve_ram #(.Width(tve_pkg::SqBits), .Depth(MAX_WIDTH)) u_hsq_ram (
    .clk_i   (clk_i),
    .we_i    (s1_q & s1_cpos_q),
    .waddr_i (s1_col_q - 1'b1),
    .wdata_i (h_sq),
    .raddr_i (col_q),
    .rdata_o (hsq_rd)
  );

  always_comb begin
    v_sq          = tve_pkg::sq_diff(s1_u_q, pix_rd);
    h_sq          = tve_pkg::sq_diff(s1_u_q, s1_prev_q);
    above_h       = s1_lcol_q ? '0 : hsq_rd;
    job_d.v_vld   = s1_rpos_q;
    job_d.v_rad   = tve_pkg::RadBits'(above_h) + tve_pkg::RadBits'(v_sq);
    job_d.h_vld   = s1_cpos_q & s1_lrow_q;
    job_d.h_sq    = h_sq;
    job_d.d_sq    = tve_pkg::sq_diff(s1_u_q, s1_u0_q);
    job_d.lambda  = s1_lambda_q;
    job_d.last    = s1_lcol_q & s1_lrow_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      prev_q <= '0;
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
    end else begin
      s1_q <= accept;
      if (s1_q) begin
        s2_q <= 1'b1;
      end else if (job_ready_i) begin
        s2_q <= 1'b0;
      end
      if (clear_i) begin
        col_q  <= '0;
        row_q  <= '0;
        prev_q <= '0;
      end else if (accept) begin
        prev_q <= u_i;
        if (last_col && last_row) begin
          col_q  <= '0;
          row_q  <= '0;
          prev_q <= '0;
        end else if (last_col) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_u_q      <= u_i;
      s1_u0_q     <= u0_i;
      s1_prev_q   <= prev_q;
      s1_col_q    <= col_q;
      s1_cpos_q   <= (col_q != '0);
      s1_rpos_q   <= (row_q != '0);
      s1_lcol_q   <= last_col;
      s1_lrow_q   <= last_row;
      s1_lambda_q <= lambda_i;
    end
    if (s1_q) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = s2_q;
  assign job_o       = job_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0({s1_q, s2_q}))
    else $error("Front stages hold two pixels at once.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_q |=> s2_q)
    else $error("Front pixel lost between stages.");
`endif

endmodule

>>> hdl/tve_back.sv
module tve_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  logic                              job_empty_i,
  input  tve_pkg::job_t                     job_i,
  output logic                              job_pop_o,
  output logic                              empty,
  input  logic                              pop,
  output logic [tve_pkg::EnergyBits-1:0]    energy_o
);

  tve_pkg::bk_state_e               state_q, state_d;
  tve_pkg::job_t                    job_q;
  logic [tve_pkg::ProdBits-1:0]     prod_q;
  logic [tve_pkg::SumBits-1:0]      grad_q;
  logic [tve_pkg::SumBits-1:0]      data_q;
  logic                             out_vld_q;
  logic [tve_pkg::EnergyBits-1:0]   energy_q;

  logic                             sq_start;
  logic [2*tve_pkg::RootBits-1:0]   sq_rad;
  logic                             sq_done;
  logic [tve_pkg::RootBits-1:0]     sq_root;
  logic                             emit;

  logic [tve_pkg::SumBits:0]        data_add;
  logic [tve_pkg::SumBits:0]        grad_add;
  logic [tve_pkg::SumBits:0]        e_sum;
  logic [tve_pkg::EnergyBits-1:0]   e_val;

  tve_sqrt #(.RootBits(tve_pkg::RootBits)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    data_add = {1'b0, data_q} + (tve_pkg::SumBits+1)'(prod_q);
    grad_add = {1'b0, grad_q} + (tve_pkg::SumBits+1)'(sq_root);
    e_sum    = {1'b0, grad_q} + (tve_pkg::SumBits+1)'(data_q >> tve_pkg::DataShift);
    e_val    = (e_sum[tve_pkg::SumBits:tve_pkg::EnergyBits] != '0) ? '1
             : e_sum[tve_pkg::EnergyBits-1:0];
  end

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    sq_start  = 1'b0;
    sq_rad    = (2*tve_pkg::RootBits)'(job_q.v_rad);
    emit      = 1'b0;
    unique case (state_q)
      tve_pkg::BkIdle: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          state_d   = tve_pkg::BkData;
        end
      end
      tve_pkg::BkData: begin
        if (job_q.v_vld) begin
          sq_start = 1'b1;
          state_d  = tve_pkg::BkWaitV;
        end else if (job_q.h_vld) begin
          sq_start = 1'b1;
          sq_rad   = (2*tve_pkg::RootBits)'(job_q.h_sq);
          state_d  = tve_pkg::BkWaitH;
        end else begin
          state_d = tve_pkg::BkTail;
        end
      end
      tve_pkg::BkWaitV: begin
        if (sq_done) begin
          if (job_q.h_vld) begin
            sq_start = 1'b1;
            sq_rad   = (2*tve_pkg::RootBits)'(job_q.h_sq);
            state_d  = tve_pkg::BkWaitH;
          end else begin
            state_d = tve_pkg::BkTail;
          end
        end
      end
      tve_pkg::BkWaitH: begin
        if (sq_done) begin
          state_d = tve_pkg::BkTail;
        end
      end
      tve_pkg::BkTail: begin
        if (!job_q.last) begin
          state_d = tve_pkg::BkIdle;
        end else if (!out_vld_q) begin
          emit    = 1'b1;
          state_d = tve_pkg::BkIdle;
        end
      end
      default: state_d = tve_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tve_pkg::BkIdle;
      grad_q    <= '0;
      data_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop && out_vld_q) begin
        out_vld_q <= 1'b0;
      end
      if (clear_i || emit) begin
        grad_q <= '0;
        data_q <= '0;
      end else begin
        if (state_q == tve_pkg::BkData) begin
          data_q <= data_add[tve_pkg::SumBits] ? '1 : data_add[tve_pkg::SumBits-1:0];
        end
        if (sq_done) begin
          grad_q <= grad_add[tve_pkg::SumBits] ? '1 : grad_add[tve_pkg::SumBits-1:0];
        end
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q  <= job_i;
      prod_q <= tve_pkg::ProdBits'(job_i.lambda) * tve_pkg::ProdBits'(job_i.d_sq);
    end
    if (emit) begin
      energy_q <= e_val;
    end
  end

  assign empty    = ~out_vld_q;
  assign energy_o = energy_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   sq_done |-> (state_q == tve_pkg::BkWaitV || state_q == tve_pkg::BkWaitH))
    else $error("Square root finished with no pixel waiting for it.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> job_q.last)
    else $error("Energy emitted before the last pixel of the frame.");
`endif

endmodule
